@@ hdl/lmwm_pkg.sv @@
// Shared types and constants of the line running max/min filter.
package lmwm_pkg;

	// Fixed widths of the stream fields and of the configuration port
	localparam int PIX_W      = 16;
	localparam int RADIUS_W   = 6;
	localparam int CFG_DATA_W = 6;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIUS = 2'd0,
		CFG_MODE   = 2'd1
	} cfg_reg_t;

	// Control broadcast to every cell of the chain
	typedef struct packed {
		logic en;        // an item is accepted this cycle
		logic first;     // item is the first pixel of a line
	} cell_ctrl_t;

endpackage

@@ hdl/lmwm_stream_if.sv @@
// Valid/ready stream interfaces for input pixels and filtered pixels.
interface lmwm_in_if
	import lmwm_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	logic             line_end;

	modport source (output valid, output pixel_in, output line_end, input ready);
	modport sink   (input valid, input pixel_in, input line_end, output ready);
endinterface

interface lmwm_out_if
	import lmwm_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             out_last;

	modport source (output valid, output pixel_out, output out_last, input ready);
	modport sink   (input valid, input pixel_out, input out_last, output ready);
endinterface

@@ hdl/line_morphology_window_max_min_unit.sv @@
// Stages: a pixel completing a window is registered in stage 1, its result in stage 2.
// Throughput: one pixel per cycle along a line while the output is not stalled; a line-end
//   pixel holds the input while the output sequencer drains the remaining positions from
//   the cell chain, one output per cycle while the output is not stalled.
// Reset: clears the pixel count, the pipeline valids and loads radius 1, mode 0;
//   the cells are not cleared and need no clearing pass.
module line_morphology_window_max_min_unit
	import lmwm_pkg::*;
#(
	parameter int PIXEL_BITS = 16,
	parameter int RADIUS_MAX = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lmwm_in_if.sink               line_in,
	lmwm_out_if.source            line_out
);

	localparam int NCELL    = 2 * RADIUS_MAX + 1;
	localparam int IDX_W    = $clog2(NCELL);
	localparam int RAD_W    = $clog2(RADIUS_MAX + 1);
	localparam int SEEN_SAT = RADIUS_MAX + 1;
	localparam int SEEN_W   = $clog2(SEEN_SAT + 1);

	// Configuration
	logic [RADIUS_W-1:0] radius_q;
	logic                mode_q;
	logic [RAD_W-1:0]    r_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_W'(1);
			mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				CFG_MODE:   mode_q   <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	assign r_eff = (int'(radius_q) > RADIUS_MAX) ? RAD_W'(RADIUS_MAX) : RAD_W'(radius_q);

	// Handshake and sequencing signals
	logic               valid_s1;
	logic               flush_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               valid_s2;
	logic [PIX_W-1:0]   pix_s2;
	logic               last_s2;
	logic [SEEN_W-1:0]  seen_q;
	logic [SEEN_W-1:0]  seen_nxt;
	logic               out_free;
	logic               s1_adv;
	logic               s1_final;
	logic               in_acc;
	logic               long_enough;
	logic               emit;
	logic [RAD_W-1:0]   first_age;
	logic [IDX_W-1:0]   start_idx;

	assign out_free      = !valid_s2 || line_out.ready;
	assign s1_adv        = valid_s1 && out_free;
	assign s1_final      = !flush_s1 || (idx_s1 == IDX_W'(r_eff));
	assign line_in.ready = !valid_s1 || (s1_adv && s1_final);
	assign in_acc        = line_in.valid && line_in.ready;

	// Pixel count of the current line, saturating once it exceeds any radius
	always_comb begin
		seen_nxt    = (seen_q == SEEN_W'(SEEN_SAT)) ? seen_q : seen_q + SEEN_W'(1);
		long_enough = seen_nxt > SEEN_W'(r_eff);
		emit        = line_in.line_end || long_enough;
		// Oldest center age still to emit at line end
		first_age   = long_enough ? r_eff : RAD_W'(seen_nxt - SEEN_W'(1));
		start_idx   = line_in.line_end ? IDX_W'(first_age) + IDX_W'(r_eff)
		                               : IDX_W'(r_eff) + IDX_W'(r_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (in_acc) begin
			seen_q <= line_in.line_end ? '0 : seen_nxt;
		end
	end

	// Cell chain: cell i keeps the max and min of the last i+1 pixels, clipped to the line
	cell_ctrl_t            ctrl;
	logic [PIXEL_BITS-1:0] cur;
	logic [PIXEL_BITS-1:0] chain_max [NCELL];
	logic [PIXEL_BITS-1:0] chain_min [NCELL];

	assign cur        = PIXEL_BITS'(line_in.pixel_in);
	assign ctrl.en    = in_acc;
	assign ctrl.first = (seen_q == '0);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		lmwm_cell #(
			.PIXEL_BITS(PIXEL_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.cur      (cur),
			.prev_max ((i == 0) ? cur : chain_max[(i == 0) ? 0 : i - 1]),
			.prev_min ((i == 0) ? cur : chain_min[(i == 0) ? 0 : i - 1]),
			.acc_max  (chain_max[i]),
			.acc_min  (chain_min[i])
		);
	end

	// Stage 1: tap to read; at line end it walks down from the oldest center
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flush_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (in_acc) begin
			valid_s1 <= emit;
			flush_s1 <= line_in.line_end;
			idx_s1   <= start_idx;
		end else if (s1_adv) begin
			if (s1_final) begin
				valid_s1 <= 1'b0;
			end else begin
				idx_s1 <= idx_s1 - IDX_W'(1);
			end
		end
	end

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
		end else if (line_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pix_s2  <= PIX_W'(mode_q ? chain_min[idx_s1] : chain_max[idx_s1]);
			last_s2 <= flush_s1 && (idx_s1 == IDX_W'(r_eff));
		end
	end

	assign line_out.valid     = valid_s2;
	assign line_out.pixel_out = pix_s2;
	assign line_out.out_last  = last_s2;

	// Checks
	a_hold_during_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_final) |-> !line_in.ready)
		else $error("pixel accepted while line-end outputs are pending");

	a_line_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && line_in.line_end) |=> (valid_s1 && flush_s1))
		else $error("line end did not start the flush");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && flush_s1 && idx_s1 == IDX_W'(r_eff)) |=>
		(line_out.valid && line_out.out_last))
		else $error("final output of line not marked");

	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= SEEN_W'(SEEN_SAT))
		else $error("pixel count beyond saturation");

endmodule

@@ hdl/lmwm_cell.sv @@
// One cell of the chain: running max and min over the last few pixels of the line.
module lmwm_cell
	import lmwm_pkg::*;
#(
	parameter int PIXEL_BITS = 16
) (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [PIXEL_BITS-1:0] cur,
	input  logic [PIXEL_BITS-1:0] prev_max,
	input  logic [PIXEL_BITS-1:0] prev_min,
	output logic [PIXEL_BITS-1:0] acc_max,
	output logic [PIXEL_BITS-1:0] acc_min
);

	logic [PIXEL_BITS-1:0] max_q;
	logic [PIXEL_BITS-1:0] min_q;
	logic [PIXEL_BITS-1:0] pick_max;
	logic [PIXEL_BITS-1:0] pick_min;

	// Both extremes are kept so a mode change mid-line applies to the whole window
	always_comb begin
		pick_max = (ctrl.first || (cur > prev_max)) ? cur : prev_max;
		pick_min = (ctrl.first || (cur < prev_min)) ? cur : prev_min;
	end

	// Line start drops the neighbor, so the window clips at the line head
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			max_q <= pick_max;
			min_q <= pick_min;
		end
	end

	assign acc_max = max_q;
	assign acc_min = min_q;

endmodule

@@ dv/line_morphology_window_max_min_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench of the line running max/min filter: table-driven lines, then random lines.
module line_morphology_window_max_min_unit_test;
	import lmwm_pkg::*;

	localparam logic MODE_DILATE = 1'b0;
	localparam logic MODE_ERODE  = 1'b1;
	// Indexes past the register list; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int HIST_LEN      = 126;  // twice the largest radius
	localparam int SEEN_CAP      = 127;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PIXELS = 260;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} filt_item_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	// One table row: either a pixel or a register write
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [PIX_W-1:0]      value;
		logic                  eol;
		logic                  typed;       // result typed in below
		logic                  has_result;
		filt_item_t            res;
	} dir_row_t;

	localparam filt_item_t NO_RES = '0;
	localparam int DIR_ROWS = 34;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// reset settings: radius 1, dilation
		'{ROW_PIXEL, CFG_RADIUS, 16'h0000, 1'b0, 1'b1, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'hFFFF, 1'b0, 1'b1, 1'b1, '{16'hFFFF, 1'b0}},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0000, 1'b1, 1'b0, 1'b0, NO_RES},
		// one-pixel line
		'{ROW_PIXEL, CFG_RADIUS, 16'h1234, 1'b1, 1'b1, 1'b1, '{16'h1234, 1'b1}},
		// radius zero passes pixels through; spare indexes ignored
		'{ROW_WRITE, CFG_RADIUS, 16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_WRITE, CFG_MODE, {15'd0, MODE_ERODE}, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_WRITE, CFG_SPARE_A, 16'h003F, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_WRITE, CFG_SPARE_B, 16'h003F, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'hFFFF, 1'b0, 1'b1, 1'b1, '{16'hFFFF, 1'b0}},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0001, 1'b0, 1'b1, 1'b1, '{16'h0001, 1'b0}},
		'{ROW_PIXEL, CFG_RADIUS, 16'h8000, 1'b1, 1'b1, 1'b1, '{16'h8000, 1'b1}},
		// radius 3: line shorter than the window, then a longer line
		'{ROW_WRITE, CFG_RADIUS, 16'h0003, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h00F0, 1'b0, 1'b1, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0F00, 1'b0, 1'b1, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h000F, 1'b1, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0400, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0001, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'hFFFE, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0002, 1'b0, 1'b0, 1'b0, NO_RES},
		// mode switched in the middle of the line
		'{ROW_WRITE, CFG_MODE, {15'd0, MODE_DILATE}, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0003, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h7FFF, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0000, 1'b1, 1'b0, 1'b0, NO_RES},
		// largest radius, erosion, short line
		'{ROW_WRITE, CFG_RADIUS, 16'h003F, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_WRITE, CFG_MODE, {15'd0, MODE_ERODE}, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0005, 1'b0, 1'b1, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0009, 1'b0, 1'b1, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'hFFFF, 1'b1, 1'b0, 1'b0, NO_RES},
		// radius 2, dilation
		'{ROW_WRITE, CFG_RADIUS, 16'h0002, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_WRITE, CFG_MODE, {15'd0, MODE_DILATE}, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'hAAAA, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h5555, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
		'{ROW_PIXEL, CFG_RADIUS, 16'hFFFF, 1'b1, 1'b0, 1'b0, NO_RES}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lmwm_in_if  pix_in ();
	lmwm_out_if pix_out ();

	line_morphology_window_max_min_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.line_in   (pix_in),
		.line_out  (pix_out)
	);

	always #5 clk = ~clk;

	// Run limit, far above the slowest correct run
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// Filter state mirrored by the bench
	logic [PIX_W-1:0]    hist [HIST_LEN];
	int                  seen_cnt = 0;
	logic [RADIUS_W-1:0] win_radius = 6'd1;
	logic                win_erode = MODE_DILATE;
	filt_item_t          step_out [$];
	filt_item_t          pending_out [$];
	int                  mismatches = 0;

	// Typed result of the item on the input, if any
	logic       row_typed = 1'b0;
	logic       row_has_res = 1'b0;
	filt_item_t row_res = '0;
	logic       tx_steady = 1'b0;

	// Window max/min outputs caused by one pixel, oldest position first
	function automatic void window_extremes(input logic [PIX_W-1:0] px, input logic eol);
		int n;
		int r;
		int first;
		int lo;
		int hi;
		logic [PIX_W-1:0] acc;
		filt_item_t res;
		step_out.delete();
		r = int'(win_radius);
		n = (seen_cnt + 1 > SEEN_CAP) ? SEEN_CAP : seen_cnt + 1;
		if (n > r)
			first = r;
		else if (eol)
			first = n - 1;
		else
			first = -1;
		// line end flushes every position down to the newest one
		lo = eol ? 0 : first;
		for (int a = first; a >= lo && a >= 0; a--) begin
			hi = (a + r > n - 1) ? n - 1 : a + r;
			acc = px;
			for (int k = 1; k <= hi; k++)
				if (win_erode ? (hist[k-1] < acc) : (hist[k-1] > acc))
					acc = hist[k-1];
			res.pixel = acc;
			res.last = eol && (a == 0);
			step_out.push_back(res);
		end
		if (eol) begin
			seen_cnt = 0;
		end else begin
			for (int k = HIST_LEN - 1; k > 0; k--)
				hist[k] = hist[k-1];
			hist[0] = px;
			seen_cnt = n;
		end
	endfunction

	// Register writes, accepted items and results, all taken at the clock edge
	always @(posedge clk) begin : scoreboard
		filt_item_t got;
		filt_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RADIUS: win_radius = cfg_data[RADIUS_W-1:0];
					CFG_MODE:   win_erode = cfg_data[0];
					default: ;
				endcase
			end
			if (pix_in.valid && pix_in.ready) begin
				window_extremes(pix_in.pixel_in, pix_in.line_end);
				if (row_typed) begin
					step_out.delete();
					if (row_has_res)
						step_out.push_back(row_res);
				end
				foreach (step_out[i])
					pending_out.push_back(step_out[i]);
			end
			if (pix_out.valid && pix_out.ready) begin
				got.pixel = pix_out.pixel_out;
				got.last = pix_out.out_last;
				if (pending_out.size() == 0) begin
					mismatches++;
					$display("%0t ns: expected no item, got pixel_out %h out_last %b",
						$time, got.pixel, got.last);
				end else begin
					want = pending_out.pop_front();
					if (got.pixel !== want.pixel) begin
						mismatches++;
						$display("%0t ns: pixel_out expected %h, got %h",
							$time, want.pixel, got.pixel);
					end
					if (got.last !== want.last) begin
						mismatches++;
						$display("%0t ns: out_last expected %b, got %b",
							$time, want.last, got.last);
					end
				end
			end
		end
	end

	// Receiver: random stall after each item, with steady stretches
	initial begin : receiver
		int hold;
		logic rx_steady;
		hold = 0;
		rx_steady = 1'b0;
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pix_out.valid && pix_out.ready) begin
				if ($urandom_range(0, 31) == 0)
					rx_steady = !rx_steady;
				hold = rx_steady ? 0 : $urandom_range(0, 9);
			end
			if (hold > 0) begin
				hold--;
				pix_out.ready <= 1'b0;
			end else begin
				pix_out.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Offer one pixel after a random gap and hold it until taken
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic eol, input logic typed,
			input logic has_res, input filt_item_t res);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.pixel_in <= px;
		pix_in.line_end <= eol;
		row_typed <= typed;
		row_has_res <= has_res;
		row_res <= res;
		do @(posedge clk); while (!pix_in.ready);
	endtask

	// Stop sending until every awaited item is out, then let the pipeline settle
	task automatic wait_idle();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int sent;
		int phase;
		int rad;
		int n_lines;
		int len;
		logic erode;
		logic [PIX_W-1:0] px;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RADIUS;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.pixel_in = '0;
		pix_in.line_end = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_WRITE) begin
				if (i == 0 || DIRECTED[i-1].kind == ROW_PIXEL)
					wait_idle();
				write_reg(DIRECTED[i].idx, DIRECTED[i].value[CFG_DATA_W-1:0]);
			end else begin
				if (i > 0 && DIRECTED[i-1].kind == ROW_WRITE)
					cfg_we <= 1'b0;
				send_pixel(DIRECTED[i].value, DIRECTED[i].eol, DIRECTED[i].typed,
					DIRECTED[i].has_result, DIRECTED[i].res);
			end
		end

		// Random lines, several settings per run, extremes first
		sent = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			case (phase)
				0: begin rad = 63; erode = MODE_DILATE; end
				1: begin rad = 0; erode = MODE_ERODE; end
				2: begin rad = 1; erode = MODE_ERODE; end
				3: begin rad = 63; erode = MODE_ERODE; end
				default: begin
					rad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
					erode = 1'($urandom_range(0, 1));
				end
			endcase
			wait_idle();
			write_reg(CFG_RADIUS, 6'(rad));
			write_reg(CFG_MODE, {5'd0, erode});
			cfg_we <= 1'b0;
			n_lines = $urandom_range(2, 4);
			for (int ln = 0; ln < n_lines; ln++) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				// one line past the pixel count limit, a few long ones, mostly short
				if (phase == 0 && ln == 0)
					len = 140;
				else if ($urandom_range(0, 15) == 0)
					len = $urandom_range(64, 140);
				else
					len = $urandom_range(1, (2 * rad + 3 < 40) ? 2 * rad + 3 : 40);
				for (int k = 0; k < len; k++) begin
					case ($urandom_range(0, 3))
						0: px = 16'($urandom_range(0, 15));
						1: px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
						default: px = 16'($urandom());
					endcase
					send_pixel(px, k == len - 1, 1'b0, 1'b0, NO_RES);
				end
				sent += len;
				if ($urandom_range(0, 7) == 0)
					wait_idle();
			end
			phase++;
		end

		wait_idle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
